>>> sv/pfd_pkg.sv
// Shared types, constants and helper functions for the Playfair digraph decryptor.
// Used by every module of the block; depends on nothing else.
package pfd_pkg;

    localparam int unsigned SIDE    = 5;
    localparam int unsigned CELLS   = SIDE * SIDE;
    localparam int unsigned LETTERS = 26;

    localparam logic [4:0] LETTER_J    = 5'd9;
    localparam logic [4:0] LAST_LETTER = 5'(LETTERS - 1);
    localparam logic [4:0] CELL_COUNT  = 5'(CELLS);
    localparam logic [2:0] LAST_INDEX  = 3'(SIDE - 1);

    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_KEY     = 2'd1;
    localparam logic [1:0] MODE_DECRYPT = 2'd2;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_KEY,
        K_DECRYPT
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [4:0] a;
        logic [4:0] b;
        logic       bad;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_POS,
        S_CELL,
        S_OUT
    } t_state;

    function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
        return ({2'b00, row} << 2) + {2'b00, row} + {2'b00, col};
    endfunction

    function automatic logic [2:0] prev_index(input logic [2:0] idx);
        return (idx == 3'd0) ? LAST_INDEX : idx - 3'd1;
    endfunction

endpackage

>>> sv/pfd_front.sv
// Input side of the decryptor: accepts words and sorts them into queue operations.
// Depends on pfd_pkg.
module pfd_front (
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_mode,
    input  logic [4:0]       i_letter_a,
    input  logic [4:0]       i_letter_b,
    input  pfd_pkg::t_q_status i_q_status,
    output logic             o_push,
    output pfd_pkg::t_op     o_op
);

    logic w_keep;

    assign o_ready = !i_q_status.full;

    always_comb begin
        w_keep      = 1'b1;
        o_op.kind   = pfd_pkg::K_CLEAR;
        o_op.a      = i_letter_a;
        o_op.b      = i_letter_b;
        o_op.bad    = (i_letter_a > pfd_pkg::LAST_LETTER) || (i_letter_b > pfd_pkg::LAST_LETTER)
                   || (i_letter_a == pfd_pkg::LETTER_J) || (i_letter_b == pfd_pkg::LETTER_J);
        case (i_mode)
            pfd_pkg::MODE_CLEAR:   o_op.kind = pfd_pkg::K_CLEAR;
            pfd_pkg::MODE_KEY:     o_op.kind = pfd_pkg::K_KEY;
            pfd_pkg::MODE_DECRYPT: o_op.kind = pfd_pkg::K_DECRYPT;
            default:               w_keep    = 1'b0;
        endcase
    end

    assign o_push = i_valid && !i_q_status.full && w_keep;

endmodule

>>> sv/pfd_queue.sv
// Two-entry queue of operations between the input side and the execution engine.
// Depends on pfd_pkg.
module pfd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pfd_pkg::t_op       i_op,
    input  logic               i_pop,
    output pfd_pkg::t_op       o_op,
    output pfd_pkg::t_q_status o_status
);

    pfd_pkg::t_op r_entry [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_count;
    logic [1:0]   n_count;

    assign o_op           = r_entry[r_rptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= n_count;
        end
    end

endmodule

>>> sv/pfd_back.sv
// Execution engine: key square and position memories, completion walk and decrypt lookup.
// Holds the output register. Depends on pfd_pkg.
module pfd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfd_pkg::t_q_status i_q_status,
    input  pfd_pkg::t_op       i_q_op,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [4:0]         o_plain_a,
    output logic [4:0]         o_plain_b,
    output logic               o_status
);

    pfd_pkg::t_state r_state;
    pfd_pkg::t_state n_state;

    logic [4:0] r_square [pfd_pkg::CELLS];
    logic [5:0] r_pos    [pfd_pkg::LETTERS];

    logic [25:0] r_used;
    logic [4:0]  r_filled;
    logic [2:0]  r_fill_row;
    logic [2:0]  r_fill_col;
    logic        r_complete;
    logic [4:0]  r_walk;
    logic [4:0]  r_a;
    logic [4:0]  r_b;
    logic        r_bad;
    logic [5:0]  r_pos_a;
    logic [5:0]  r_pos_b;
    logic [4:0]  r_cell_a;
    logic [4:0]  r_cell_b;
    logic        r_out_valid;
    logic [4:0]  r_out_a;
    logic [4:0]  r_out_b;
    logic        r_out_status;

    logic [31:0] w_used_ext;
    logic        w_room;
    logic        w_out_free;
    logic        w_wr_en;
    logic [4:0]  w_wr_letter;
    logic        w_pos_rd;
    logic [4:0]  w_pos_addr_a;
    logic [4:0]  w_pos_addr_b;
    logic        w_sq_rd;
    logic [4:0]  w_sq_addr_a;
    logic [4:0]  w_sq_addr_b;
    logic        w_out_load;
    logic        w_walk_start;
    logic        w_walk_done;
    logic [2:0]  w_ra;
    logic [2:0]  w_ca;
    logic [2:0]  w_rb;
    logic [2:0]  w_cb;

    assign w_used_ext = {6'b000000, r_used};
    assign w_room     = (r_filled < pfd_pkg::CELL_COUNT);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_walk_done = (r_walk == pfd_pkg::LAST_LETTER);

    assign w_ra = r_pos_a[5:3];
    assign w_ca = r_pos_a[2:0];
    assign w_rb = r_pos_b[5:3];
    assign w_cb = r_pos_b[2:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfd_pkg::S_IDLE: begin
                if (!i_q_status.empty && i_q_op.kind == pfd_pkg::K_DECRYPT) begin
                    if (!r_complete) begin
                        n_state = pfd_pkg::S_FILL;
                    end else if (i_q_op.bad) begin
                        n_state = pfd_pkg::S_OUT;
                    end else begin
                        n_state = pfd_pkg::S_CELL;
                    end
                end
            end
            pfd_pkg::S_FILL: begin
                if (w_walk_done) begin
                    n_state = r_bad ? pfd_pkg::S_OUT : pfd_pkg::S_POS;
                end
            end
            pfd_pkg::S_POS:  n_state = pfd_pkg::S_CELL;
            pfd_pkg::S_CELL: n_state = pfd_pkg::S_OUT;
            pfd_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = pfd_pkg::S_IDLE;
                end
            end
            default: n_state = pfd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop      = 1'b0;
        w_wr_en      = 1'b0;
        w_wr_letter  = i_q_op.a;
        w_pos_rd     = 1'b0;
        w_pos_addr_a = r_a;
        w_pos_addr_b = r_b;
        w_sq_rd      = 1'b0;
        w_out_load   = 1'b0;
        w_walk_start = 1'b0;
        case (r_state)
            pfd_pkg::S_IDLE: begin
                o_q_pop      = !i_q_status.empty;
                w_pos_addr_a = i_q_op.a;
                w_pos_addr_b = i_q_op.b;
                if (!i_q_status.empty) begin
                    case (i_q_op.kind)
                        pfd_pkg::K_KEY: begin
                            w_wr_en = (i_q_op.a <= pfd_pkg::LAST_LETTER)
                                   && !w_used_ext[i_q_op.a] && w_room;
                        end
                        pfd_pkg::K_DECRYPT: begin
                            w_walk_start = !r_complete;
                            w_pos_rd     = r_complete && !i_q_op.bad;
                        end
                        default: ;
                    endcase
                end
            end
            pfd_pkg::S_FILL: begin
                w_wr_letter = r_walk;
                w_wr_en     = !w_used_ext[r_walk] && w_room;
            end
            pfd_pkg::S_POS:  w_pos_rd   = 1'b1;
            pfd_pkg::S_CELL: w_sq_rd    = 1'b1;
            pfd_pkg::S_OUT:  w_out_load = w_out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (w_ra == w_rb) begin
            w_sq_addr_a = pfd_pkg::cell_addr(w_ra, pfd_pkg::prev_index(w_ca));
            w_sq_addr_b = pfd_pkg::cell_addr(w_rb, pfd_pkg::prev_index(w_cb));
        end else if (w_ca == w_cb) begin
            w_sq_addr_a = pfd_pkg::cell_addr(pfd_pkg::prev_index(w_ra), w_ca);
            w_sq_addr_b = pfd_pkg::cell_addr(pfd_pkg::prev_index(w_rb), w_cb);
        end else begin
            w_sq_addr_a = pfd_pkg::cell_addr(w_ra, w_cb);
            w_sq_addr_b = pfd_pkg::cell_addr(w_rb, w_ca);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_square[r_filled] <= w_wr_letter;
            r_pos[w_wr_letter] <= {r_fill_row, r_fill_col};
        end
        if (w_pos_rd) begin
            r_pos_a <= r_pos[w_pos_addr_a];
            r_pos_b <= r_pos[w_pos_addr_b];
        end
        if (w_sq_rd) begin
            r_cell_a <= r_square[w_sq_addr_a];
            r_cell_b <= r_square[w_sq_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a   <= i_q_op.a;
            r_b   <= i_q_op.b;
            r_bad <= i_q_op.bad;
        end
        if (w_walk_start) begin
            r_walk <= 5'd0;
        end else if (r_state == pfd_pkg::S_FILL) begin
            r_walk <= r_walk + 5'd1;
        end
        if (w_out_load) begin
            r_out_a      <= r_bad ? 5'd0 : r_cell_a;
            r_out_b      <= r_bad ? 5'd0 : r_cell_b;
            r_out_status <= r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfd_pkg::S_IDLE;
            r_used      <= 26'd1 << pfd_pkg::LETTER_J;
            r_filled    <= 5'd0;
            r_fill_row  <= 3'd0;
            r_fill_col  <= 3'd0;
            r_complete  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_pop && i_q_op.kind == pfd_pkg::K_CLEAR) begin
                r_used     <= 26'd1 << pfd_pkg::LETTER_J;
                r_filled   <= 5'd0;
                r_fill_row <= 3'd0;
                r_fill_col <= 3'd0;
                r_complete <= 1'b0;
            end else if (w_wr_en) begin
                r_used   <= r_used | (26'd1 << w_wr_letter);
                r_filled <= r_filled + 5'd1;
                if (r_fill_col == pfd_pkg::LAST_INDEX) begin
                    r_fill_col <= 3'd0;
                    r_fill_row <= r_fill_row + 3'd1;
                end else begin
                    r_fill_col <= r_fill_col + 3'd1;
                end
            end
            if (r_state == pfd_pkg::S_FILL && w_walk_done) begin
                r_complete <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_plain_a = r_out_a;
    assign o_plain_b = r_out_b;
    assign o_status  = r_out_status;

endmodule

>>> sv/playfair_digraph_decrypt.sv
// Playfair digraph decryptor with a built-in 5x5 key square: top level.
// Instantiates pfd_front, pfd_queue and pfd_back; depends on pfd_pkg.
//
// The input channel (i_valid / o_ready) takes one word per handshake: a mode,
// and one or two letters. Mode 0 clears the square, mode 1 adds a key letter,
// mode 2 decrypts a pair, and mode 3 is taken and dropped. Only mode 2 gives a
// word on the output channel (o_valid / i_ready): two plaintext letters and a
// status bit that is set, with both letters zero, when either letter is j or
// above z. A two-entry queue sits between the input side and the engine.
// Clear and key words are handled as they leave the queue head. A decrypt goes
// from the queue head to the output register through the position memory read,
// the square memory read and the output load; a pair with j or a letter above z
// skips both reads. The first decrypt after key entry adds the walk that fills
// the free cells, plus a separate position read state when the pair is good.
// Reset empties the queue and the output register and leaves an empty square.
// When the receiver stalls, the result holds in the output register, the
// engine stops at its next result, and the queue keeps taking words until full.
module playfair_digraph_decrypt (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  logic [4:0] i_letter_a,
    input  logic [4:0] i_letter_b,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [4:0] o_plain_a,
    output logic [4:0] o_plain_b,
    output logic       o_status
);

    pfd_pkg::t_q_status w_q_status;
    pfd_pkg::t_op       w_push_op;
    pfd_pkg::t_op       w_head_op;
    logic               w_push;
    logic               w_pop;

    pfd_front u_front (
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_mode     (i_mode),
        .i_letter_a (i_letter_a),
        .i_letter_b (i_letter_b),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_op       (w_push_op)
    );

    pfd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_op     (w_push_op),
        .i_pop    (w_pop),
        .o_op     (w_head_op),
        .o_status (w_q_status)
    );

    pfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_q_op     (w_head_op),
        .o_q_pop    (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_plain_a  (o_plain_a),
        .o_plain_b  (o_plain_b),
        .o_status   (o_status)
    );

endmodule
